// ===== hdl/lsb_payload_extractor_crc_unit_assert.svh =====
// Assertion macros shared by the extractor modules.
// Each check is disabled while the synchronous reset is held low.
`ifndef LSB_PAYLOAD_EXTRACTOR_CRC_UNIT_ASSERT_SVH
`define LSB_PAYLOAD_EXTRACTOR_CRC_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define LPE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define LPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LPE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define LPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hdl/lpe_pkg.sv =====
`default_nettype none

package lpe_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 28;

    localparam logic [CFG_IDX_W-1:0] REG_LSB_BITS    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT = 1'd1;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

    typedef enum logic [1:0] {
        PH_LENGTH  = 2'd0,
        PH_CRC     = 2'd1,
        PH_MESSAGE = 2'd2,
        PH_DONE    = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_CRC_OK   = 2'd0,
        ST_CRC_BAD  = 2'd1,
        ST_TOO_LONG = 2'd2,
        ST_RAN_OUT  = 2'd3
    } t_status;

    // What one pixel produced: an optional message byte, then an optional status.
    typedef struct packed {
        logic       has_byte;
        logic [7:0] data;
        logic       has_status;
        t_status    code;
    } t_event;

endpackage

`default_nettype wire

// ===== hdl/lpe_front.sv =====
`default_nettype none

module lpe_front import lpe_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [7:0]            i_pixel,
    input  wire logic                  i_frame_end,
    input  wire logic                  i_full,
    output logic                       o_push,
    output t_event                     o_event
);

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    logic [2:0]  r_lsb_bits;
    logic [27:0] r_pixel_count;

    logic [10:0] r_buf,    n_buf;
    logic [3:0]  r_cnt,    n_cnt;
    t_phase      r_phase,  n_phase;
    logic [31:0] r_bc,     n_bc;
    logic [31:0] r_len,    n_len;
    logic [31:0] r_stored, n_stored;
    logic [31:0] r_crc,    n_crc;

    logic        w_accept;
    logic [2:0]  w_bits;
    logic [10:0] w_shift;
    logic [3:0]  w_sum;
    logic        w_byte_done;
    logic [3:0]  w_cnt_after;
    logic [7:0]  w_byte;
    logic [30:0] w_prod;
    logic [27:0] w_cap;
    logic [31:0] w_len_new;
    logic [31:0] w_stored_new;
    logic        w_too_long;
    logic [31:0] w_crc_new;
    logic        w_emit_byte;
    logic        w_emit_status;
    t_status     w_code;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lsb_bits    <= 3'd1;
            r_pixel_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LSB_BITS:    r_lsb_bits    <= i_cfg_data[2:0];
                REG_PIXEL_COUNT: r_pixel_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // bit gathering, capacity and crc
    always_comb begin
        if (r_lsb_bits inside {[3'd1:3'd4]}) begin
            w_bits = r_lsb_bits;
        end else if (r_lsb_bits == 3'd0) begin
            w_bits = 3'd1;
        end else begin
            w_bits = 3'd4;
        end
        case (w_bits)
            3'd1:    w_shift = {r_buf[9:0], i_pixel[0]};
            3'd2:    w_shift = {r_buf[8:0], i_pixel[1:0]};
            3'd3:    w_shift = {r_buf[7:0], i_pixel[2:0]};
            default: w_shift = {r_buf[6:0], i_pixel[3:0]};
        endcase
        w_sum        = r_cnt + {1'b0, w_bits};
        w_byte_done  = (w_sum >= 4'd8);
        w_cnt_after  = w_byte_done ? (w_sum - 4'd8) : w_sum;
        w_byte       = w_shift[w_cnt_after[1:0] +: 8];
        w_prod       = 31'(r_pixel_count) * 31'(w_bits);
        w_cap        = w_prod[30:3];
        w_len_new    = {r_len[23:0], w_byte};
        w_stored_new = {r_stored[23:0], w_byte};
        w_too_long   = ({1'b0, w_len_new} + 33'd8) > {5'd0, w_cap};
        w_crc_new    = crc_byte(r_crc, w_byte);
    end

    // next state
    always_comb begin
        n_buf         = r_buf;
        n_cnt         = r_cnt;
        n_phase       = r_phase;
        n_bc          = r_bc;
        n_len         = r_len;
        n_stored      = r_stored;
        n_crc         = r_crc;
        w_emit_byte   = 1'b0;
        w_emit_status = 1'b0;
        w_code        = ST_CRC_OK;
        if (r_phase != PH_DONE) begin
            n_buf = w_shift;
            n_cnt = w_cnt_after;
            if (w_byte_done) begin
                case (r_phase)
                    PH_LENGTH: begin
                        n_len = w_len_new;
                        n_crc = w_crc_new;
                        if (r_bc == 32'd3) begin
                            n_bc = '0;
                            if (w_too_long) begin
                                w_emit_status = 1'b1;
                                w_code        = ST_TOO_LONG;
                                n_phase       = PH_DONE;
                            end else begin
                                n_phase = PH_CRC;
                            end
                        end else begin
                            n_bc = r_bc + 32'd1;
                        end
                    end
                    PH_CRC: begin
                        n_stored = w_stored_new;
                        if (r_bc == 32'd3) begin
                            n_bc    = '0;
                            n_phase = PH_MESSAGE;
                            if (r_len == 32'd0) begin
                                w_emit_status = 1'b1;
                                w_code  = ((r_crc ^ CRC_ONES) == w_stored_new) ?
                                          ST_CRC_OK : ST_CRC_BAD;
                                n_phase = PH_DONE;
                            end
                        end else begin
                            n_bc = r_bc + 32'd1;
                        end
                    end
                    PH_MESSAGE: begin
                        w_emit_byte = 1'b1;
                        n_crc       = w_crc_new;
                        n_bc        = r_bc + 32'd1;
                        if ((r_bc + 32'd1) == r_len) begin
                            w_emit_status = 1'b1;
                            w_code  = ((w_crc_new ^ CRC_ONES) == r_stored) ?
                                      ST_CRC_OK : ST_CRC_BAD;
                            n_phase = PH_DONE;
                        end
                    end
                    default: ;
                endcase
            end
        end
        if (i_frame_end) begin
            if (n_phase != PH_DONE) begin
                w_emit_status = 1'b1;
                w_code        = ST_RAN_OUT;
            end
            n_buf    = '0;
            n_cnt    = '0;
            n_phase  = PH_LENGTH;
            n_bc     = '0;
            n_len    = '0;
            n_stored = '0;
            n_crc    = CRC_ONES;
        end
    end

    // queue entry
    always_comb begin
        o_event.has_byte   = w_emit_byte;
        o_event.data       = w_byte;
        o_event.has_status = w_emit_status;
        o_event.code       = w_code;
        o_push             = w_accept && (w_emit_byte || w_emit_status);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf    <= '0;
            r_cnt    <= '0;
            r_phase  <= PH_LENGTH;
            r_bc     <= '0;
            r_len    <= '0;
            r_stored <= '0;
            r_crc    <= CRC_ONES;
        end else if (w_accept) begin
            r_buf    <= n_buf;
            r_cnt    <= n_cnt;
            r_phase  <= n_phase;
            r_bc     <= n_bc;
            r_len    <= n_len;
            r_stored <= n_stored;
            r_crc    <= n_crc;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lpe_queue.sv =====
`default_nettype none
`include "lsb_payload_extractor_crc_unit_assert.svh"

module lpe_queue import lpe_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_event i_event,
    input  wire logic   i_pop,
    output t_event      o_head,
    output logic        o_empty,
    output logic        o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_event           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_event;
        end
    end

    `LPE_ASSERT_IMPL(a_no_push_full, i_clk, i_rst_n, i_push, !o_full, "push into full queue")
    `LPE_ASSERT_IMPL(a_no_pop_empty, i_clk, i_rst_n, i_pop, !o_empty, "pop from empty queue")
    `LPE_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1, "queue count lost a push")

endmodule

`default_nettype wire

// ===== hdl/lpe_back.sv =====
`default_nettype none
`include "lsb_payload_extractor_crc_unit_assert.svh"

module lpe_back import lpe_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_event i_head,
    input  wire logic   i_empty,
    output logic        o_pop,
    output logic        o_valid,
    input  wire logic   i_ready,
    output logic [7:0]  o_byte,
    output logic        o_is_status,
    output t_status     o_status,
    output logic        o_last
);

    logic       r_valid, n_valid;
    logic       r_pend,  n_pend;
    t_status    r_pend_code, n_pend_code;
    logic [7:0] r_byte,  n_byte;
    logic       r_is,    n_is;
    t_status    r_status, n_status;
    logic       w_free;

    always_comb begin
        w_free      = !r_valid || i_ready;
        o_pop       = w_free && !r_pend && !i_empty;
        n_valid     = r_valid;
        n_pend      = r_pend;
        n_pend_code = r_pend_code;
        n_byte      = r_byte;
        n_is        = r_is;
        n_status    = r_status;
        if (w_free) begin
            if (r_pend) begin
                // status that followed the byte just taken
                n_valid  = 1'b1;
                n_pend   = 1'b0;
                n_byte   = '0;
                n_is     = 1'b1;
                n_status = r_pend_code;
            end else if (!i_empty) begin
                n_valid = 1'b1;
                if (i_head.has_byte) begin
                    n_byte      = i_head.data;
                    n_is        = 1'b0;
                    n_status    = ST_CRC_OK;
                    n_pend      = i_head.has_status;
                    n_pend_code = i_head.code;
                end else begin
                    n_byte   = '0;
                    n_is     = 1'b1;
                    n_status = i_head.code;
                end
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_code <= n_pend_code;
        r_byte      <= n_byte;
        r_is        <= n_is;
        r_status    <= n_status;
    end

    assign o_valid     = r_valid;
    assign o_byte      = r_byte;
    assign o_is_status = r_is;
    assign o_status    = r_status;
    assign o_last      = r_is;

    `LPE_ASSERT_IMPL(a_pend_after_byte, i_clk, i_rst_n, r_pend, r_valid && !r_is, "pending status without a byte shown")
    `LPE_ASSERT_IMPL(a_status_no_byte, i_clk, i_rst_n, r_valid && r_is, r_byte == 8'd0, "status item carries a byte")
    `LPE_ASSERT_IMPL(a_byte_no_code, i_clk, i_rst_n, r_valid && !r_is, r_status == ST_CRC_OK, "byte item carries a status")

endmodule

`default_nettype wire

// ===== hdl/lsb_payload_extractor_crc_unit.sv =====
// Recovers a message hidden in the low bits of pixel bytes.
// Input stream (i_s_*): one pixel byte per item, tlast on the last pixel
// of the image. Output stream (o_m_*): message bytes (tuser 0), then one
// status item (tuser 1, tlast 1): 0 crc ok, 1 crc bad, 2 length too large,
// 3 pixels ran out. A tlast pixel restarts extraction for the next image.
// Config port: index 0 lsb_bits (1..4, 0 acts as 1, above 4 as 4),
// index 1 pixel_count; write only while the block is idle.
// Throughput: one pixel item per cycle while the queue is not full. The
// front end does bit gathering, the per-byte CRC and the length check
// combinationally; a pixel with a byte and a status gives two output items.
// Path: the pixel is classified and its result queued at the edge that takes
// it; the queue head moves into the output register once that register is
// free. A status that follows a byte from the same pixel comes once that
// byte is taken.
// Receiver stall: results wait in a QUEUE_DEPTH entry queue plus the output
// register; o_s_tready drops when the queue is full.
// Reset: lsb_bits returns to 1, pixel_count to 0, queue and output empty,
// extraction starts with the length field.
`default_nettype none

module lsb_payload_extractor_crc_unit import lpe_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [7:0]            i_s_tdata,   // [7:0] pixel_byte
    input  wire logic                  i_s_tlast,   // frame_end
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [15:0]                o_m_tdata,   // [7:0] out_byte, [9:8] status
    output logic                       o_m_tuser,   // is_status
    output logic                       o_m_tlast    // last
);

    logic    w_push;
    logic    w_pop;
    logic    w_empty;
    logic    w_full;
    t_event  w_event;
    t_event  w_head;
    logic [7:0] w_byte;
    t_status w_status;

    lpe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_pixel     (i_s_tdata),
        .i_frame_end (i_s_tlast),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_event     (w_event)
    );

    lpe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_event (w_event),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    lpe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_byte      (w_byte),
        .o_is_status (o_m_tuser),
        .o_status    (w_status),
        .o_last      (o_m_tlast)
    );

    assign o_m_tdata = {6'd0, w_status, w_byte};

endmodule

`default_nettype wire
